// ===== design/cctf_pkg.sv =====
// shared types, constants and the byte-wide crc-32 update for the chunk trailer framer
// used by every module of the framer; depends on nothing
package cctf_pkg;

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned TOP_SHIFT     = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned TRAIL_CNT_W   = $clog2(TRAILER_BYTES + 1);

  // one word handed from the front part to the back part
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        chunk_end;
    logic [31:0] crc;
  } cctf_entry_t;

  // reflected crc-32 update by one byte, lsb first
  function automatic logic [31:0] crc_absorb(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] acc;
    acc = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== design/cctf_front.sv =====
// front part: accepts payload words, keeps the running crc, queues classified words
// depends on cctf_pkg
module cctf_front
  import cctf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        chunk_end,
  input  logic        full,
  output logic        push,
  output cctf_entry_t push_entry
);

  logic [31:0] running_check;
  logic [31:0] running_check_next;
  logic [31:0] absorbed;

  // accept whenever the queue has room
  assign in_stall = full;
  assign push     = in_valid && !full;

  // crc update and finished value for the trailer
  assign absorbed                = crc_absorb(running_check, payload_byte);
  assign push_entry.payload_byte = payload_byte;
  assign push_entry.chunk_end    = chunk_end;
  assign push_entry.crc          = absorbed ^ CRC_INIT;

  always_comb begin
    running_check_next = running_check;
    if (push) begin
      running_check_next = chunk_end ? CRC_INIT : absorbed;
    end
  end

  // running crc register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_check <= CRC_INIT;
    end else begin
      running_check <= running_check_next;
    end
  end

  // a chunk end restarts the crc
  assert property (@(posedge clk) disable iff (rst)
    (push && chunk_end) |=> (running_check == CRC_INIT))
    else $error("running crc not restarted after chunk end");

endmodule

// ===== design/cctf_queue.sv =====
// short word queue between the front and back parts of the framer
// depends on cctf_pkg
module cctf_queue
  import cctf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cctf_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output cctf_entry_t pop_entry,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cctf_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // no overflow or underflow
  assert property (@(posedge clk) disable iff (rst)
    (!(push && full)) && (!(pop && empty)))
    else $error("queue pushed when full or popped when empty");

endmodule

// ===== design/cctf_back.sv =====
// back part: emits each queued payload word and, after each chunk-end word, the four crc trailer words
// depends on cctf_pkg
module cctf_back
  import cctf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cctf_entry_t pop_entry,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        is_check_byte,
  output logic        frame_last
);

  logic                   load;
  logic [TRAIL_CNT_W-1:0] trail_cnt;
  logic [31:0]            crc_hold;

  // output register free to take a new word
  assign load = !out_valid || !out_stall;
  assign pop  = load && (trail_cnt == '0) && !empty;

  // trailer counter and crc shifter, most significant byte first
  always_ff @(posedge clk) begin
    if (rst) begin
      trail_cnt <= '0;
    end else if (load) begin
      if (trail_cnt != '0) begin
        trail_cnt <= trail_cnt - 1'b1;
      end else if (pop && pop_entry.chunk_end) begin
        trail_cnt <= TRAIL_CNT_W'(TRAILER_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (trail_cnt != '0) begin
        crc_hold <= crc_hold << 8;
      end else if (pop) begin
        crc_hold <= pop_entry.crc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= (trail_cnt != '0) || pop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (trail_cnt != '0) begin
        frame_byte    <= crc_hold[TOP_SHIFT +: 8];
        is_check_byte <= 1'b1;
        frame_last    <= (trail_cnt == TRAIL_CNT_W'(1));
      end else begin
        frame_byte    <= pop_entry.payload_byte;
        is_check_byte <= 1'b0;
        frame_last    <= 1'b0;
      end
    end
  end

  // last word is always a trailer word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> is_check_byte)
    else $error("last flag on a payload word");

  // no payload word is drawn while the trailer is still going out
  assert property (@(posedge clk) disable iff (rst)
    (trail_cnt != '0) |-> !pop)
    else $error("queue read during trailer");

endmodule

// ===== design/crc32_chunk_trailer_framer.sv =====
// top level of the crc-32 chunk trailer framer
// depends on cctf_pkg, cctf_front, cctf_queue and cctf_back
//
// Payload words enter one per cycle while in_stall is low and leave in order,
// each folded into a reflected crc-32 (poly edb88320, init and final xor all
// ones). A word flagged chunk_end is followed on the output by the four crc
// bytes, most significant first, the last one flagged by frame_last; the crc
// then restarts. The front takes one word per cycle while the queue
// (QUEUE_DEPTH words) has room; the output side emits one word per cycle
// while out_stall is low, so a chunk of n payload words yields n + 4 output
// words, and the trailer is what sets the sustained input rate over a chunk.
module crc32_chunk_trailer_framer
  import cctf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       chunk_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       is_check_byte,
  output logic       frame_last
);

  cctf_entry_t push_entry;
  cctf_entry_t pop_entry;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  // classify and checksum
  cctf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .chunk_end    (chunk_end),
    .full         (full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoupling queue
  cctf_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  // serialise payload and trailer
  cctf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_entry     (pop_entry),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .is_check_byte (is_check_byte),
    .frame_last    (frame_last)
  );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the crc-32 chunk trailer framer
// depends on cctf_pkg, crc32_chunk_trailer_framer, cctf_front, cctf_queue and cctf_back
`timescale 1ns / 1ps

module tb_top;
  import cctf_pkg::*;

  localparam int unsigned RANDOM_WORDS = 100;
  localparam int unsigned CALM_WORDS   = 20;
  localparam int unsigned DIR_ROWS     = 19;
  localparam int unsigned MAX_REPORTS  = 10;

  // one word expected on the output side
  typedef struct packed {
    logic [7:0] data;
    logic       check;
    logic       last;
  } frame_word_t;

  // one directed input word; crc_typed holds the known chunk crc where typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic        last_in;
    logic        typed;
    logic [31:0] crc_typed;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // single zero byte, straight after reset
    '{8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
    // single all-ones byte
    '{8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
    // the usual check string "123456789"
    '{8'h31, 1'b0, 1'b0, 32'h0}, '{8'h32, 1'b0, 1'b0, 32'h0},
    '{8'h33, 1'b0, 1'b0, 32'h0}, '{8'h34, 1'b0, 1'b0, 32'h0},
    '{8'h35, 1'b0, 1'b0, 32'h0}, '{8'h36, 1'b0, 1'b0, 32'h0},
    '{8'h37, 1'b0, 1'b0, 32'h0}, '{8'h38, 1'b0, 1'b0, 32'h0},
    '{8'h39, 1'b1, 1'b1, 32'hCBF4_3926},
    // walking patterns, checked by the predictor
    '{8'h80, 1'b0, 1'b0, 32'h0}, '{8'h01, 1'b0, 1'b0, 32'h0},
    '{8'hAA, 1'b0, 1'b0, 32'h0}, '{8'h55, 1'b1, 1'b0, 32'h0},
    // run of all-ones bytes
    '{8'hFF, 1'b0, 1'b0, 32'h0}, '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0}, '{8'hFF, 1'b1, 1'b0, 32'h0}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] payload_byte;
  logic       chunk_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] frame_byte;
  logic       is_check_byte;
  logic       frame_last;

  frame_word_t frame_q[$];
  logic [31:0] crc_run;
  int unsigned mismatches;
  int unsigned stall_left;
  bit          calm;

  crc32_chunk_trailer_framer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .chunk_end    (chunk_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .is_check_byte(is_check_byte),
    .frame_last   (frame_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on run length
  initial begin
    #2_000_000;
    $display("crc32_chunk_trailer_framer test failed");
    $finish;
  end

  // reflected crc-32 update by one byte, bit at a time
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                input logic [7:0]  data);
    logic [31:0] r;
    r = crc ^ {24'd0, data};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    end
    return r;
  endfunction

  // work out the frame words caused by one accepted input word
  task automatic predict_frame(input logic [7:0] data, input logic last_in,
                               input logic typed, input logic [31:0] crc_typed);
    logic [31:0] fin;
    crc_run = crc_fold_byte(crc_run, data);
    frame_q.push_back('{data: data, check: 1'b0, last: 1'b0});
    if (last_in) begin
      fin = typed ? crc_typed : (crc_run ^ CRC_INIT);
      for (int k = 0; k < TRAILER_BYTES; k++) begin
        frame_q.push_back('{data: fin[31 - 8 * k -: 8], check: 1'b1,
                            last: (k == TRAILER_BYTES - 1)});
      end
      crc_run = CRC_INIT;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // offer one word and hold it until accepted
  task automatic send_word(input logic [7:0] data, input logic last_in,
                           input logic typed, input logic [31:0] crc_typed);
    @(negedge clk);
    in_valid     = 1'b1;
    payload_byte = data;
    chunk_end    = last_in;
    do @(posedge clk); while (in_stall);
    predict_frame(data, last_in, typed, crc_typed);
  endtask

  // sender gap of random length, sometimes
  task automatic maybe_pause_sender();
    int unsigned n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      repeat (n) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
  endtask

  // hold the sender off until the output side has caught up
  task automatic drain_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  // receiver stall bursts, changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall = 1'b0;
      if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
    end
  end

  // compare every accepted output word with the oldest expectation
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word data=%02h check=%0b last=%0b",
                                frame_byte, is_check_byte, frame_last));
      end else begin
        want = frame_q.pop_front();
        if (frame_byte !== want.data || is_check_byte !== want.check ||
            frame_last !== want.last) begin
          note_mismatch($sformatf(
            "expected data=%02h check=%0b last=%0b, got data=%02h check=%0b last=%0b",
            want.data, want.check, want.last, frame_byte, is_check_byte, frame_last));
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned len;
    bit          drained;
    rst          = 1'b1;
    in_valid     = 1'b0;
    payload_byte = 8'h00;
    chunk_end    = 1'b0;
    out_stall    = 1'b0;
    stall_left   = 0;
    calm         = 1'b0;
    mismatches   = 0;
    crc_run      = CRC_INIT;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TAB[i].data, DIR_TAB[i].last_in, DIR_TAB[i].typed,
                DIR_TAB[i].crc_typed);
      maybe_pause_sender();
    end
    drain_outputs();

    // random chunks, mostly short, now and then a long one
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_WORDS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        calm = (sent >= RANDOM_WORDS - CALM_WORDS);
        send_word(8'($urandom_range(0, 255)), (j == len - 1), 1'b0, 32'h0);
        sent++;
        maybe_pause_sender();
      end
      if (!drained && sent >= RANDOM_WORDS / 2) begin
        drain_outputs();
        drained = 1'b1;
      end
    end

    // let the last trailer come out, then watch for stray words
    drain_outputs();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("crc32_chunk_trailer_framer test passed");
    end else begin
      $display("crc32_chunk_trailer_framer test failed");
    end
    $finish;
  end

endmodule
